// ===== rtl/lru_ttl_cache_replacement_macros.svh =====
// assertion macros for the cache tag table checker
`ifndef LRU_TTL_CACHE_REPLACEMENT_MACROS_SVH
`define LRU_TTL_CACHE_REPLACEMENT_MACROS_SVH
`define LTC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("label failed");
`define LTC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("label failed");
`endif

// ===== rtl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// types, constants and command codes of the cache tag table
// ----------------------------------------------------------------------------
package ltc_pkg;
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CAP_W    = 5;
  localparam int SLOT_W   = 4;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // scan passes run by the datapath
  typedef enum logic [2:0] {
    PASS_FIND  = 3'd0,
    PASS_EARLY = 3'd1,
    PASS_LRU   = 3'd2,
    PASS_SHIFT = 3'd3,
    PASS_INS   = 3'd4
  } pass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;     // capture input word
    logic  clear;    // reset scan index
    logic  step;     // scan one entry
    pass_t pass;
    logic  refresh;  // write expiry of hit
    logic  pick_lru; // choose lru victim
    logic  remove;   // drop victim
    logic  insert;   // write new entry
    logic  finish;   // present result
  } ctl_t;

  typedef struct packed {
    logic last;      // scan index at final entry
    logic hit;
    logic is_put;
    logic is_get;
    logic is_none;
    logic full;
    logic early_stale;
    logic have_free;
  } sts_t;
endpackage

// ===== rtl/ltc_if.sv =====
// ----------------------------------------------------------------------------
// ltc_in_if / ltc_out_if
// valid-ready channels of the cache tag table
// ----------------------------------------------------------------------------
interface ltc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  logic [15:0] max_age;
  logic [31:0] now;
  modport source (output valid, cmd, key, max_age, now, input ready);
  modport sink   (input valid, cmd, key, max_age, now, output ready);
endinterface

interface ltc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        stale;
  logic [3:0]  slot;
  logic        evicted;
  logic        evict_was_stale;
  logic [31:0] evicted_key;
  modport source (output valid, hit, stale, slot, evicted, evict_was_stale, evicted_key,
                  input ready);
  modport sink   (input valid, hit, stale, slot, evicted, evict_was_stale, evicted_key,
                  output ready);
endinterface

// ===== rtl/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltc_ctrl
// sequencer for the scan passes of one command
// ----------------------------------------------------------------------------
module ltc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_fire,
  input  ltc_pkg::sts_t sts,
  output ltc_pkg::ctl_t ctl,
  output logic          in_ready,
  output logic          out_valid
);
  import ltc_pkg::*;

  state_t state, state_next;
  pass_t  pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= PASS_FIND;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_SCAN;
          pass_next  = PASS_FIND;
        end
      end
      ST_SCAN: begin
        if (sts.last) begin
          priority case (pass)
            PASS_FIND:  state_next = ST_DECIDE;
            PASS_EARLY: begin
              pass_next  = sts.early_stale ? PASS_SHIFT : PASS_LRU;
              state_next = sts.early_stale ? ST_EVICT : ST_SCAN;
            end
            PASS_LRU:   state_next = ST_EVICT;
            PASS_SHIFT: begin
              pass_next = PASS_INS;
            end
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_DECIDE: begin
        if (sts.is_put && !sts.hit) begin
          state_next = ST_SCAN;
          pass_next  = sts.full ? PASS_EARLY : PASS_SHIFT;
        end else if (sts.is_get && sts.hit) begin
          state_next = ST_SCAN;
          pass_next  = PASS_SHIFT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_EVICT: begin
        state_next = ST_SCAN;
        pass_next  = PASS_SHIFT;
      end
      ST_DONE: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.pass     = pass;
    in_ready     = (state == ST_IDLE);
    out_valid    = (state == ST_DONE);
    ctl.load     = in_fire;
    ctl.clear    = in_fire || (state == ST_DECIDE) || (state == ST_EVICT) ||
                   (state == ST_SCAN && sts.last);
    ctl.step     = (state == ST_SCAN);
    ctl.refresh  = (state == ST_DECIDE) && sts.is_put && sts.hit;
    ctl.pick_lru = (state == ST_SCAN) && (pass == PASS_EARLY) && sts.last && !sts.early_stale;
    ctl.remove   = (state == ST_EVICT);
    ctl.insert   = (state == ST_SCAN) && (pass == PASS_SHIFT) && sts.last && !sts.hit;
    ctl.finish   = (state == ST_SCAN) && (pass == PASS_INS) && sts.last;
  end
endmodule

// ===== rtl/ltc_dp.sv =====
// ----------------------------------------------------------------------------
// ltc_dp
// entry storage and one-entry-per-cycle scan datapath
// ----------------------------------------------------------------------------
module ltc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ltc_pkg::ctl_t                 ctl,
  output ltc_pkg::sts_t                 sts,
  input  logic [ltc_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    in_cmd,
  input  logic [31:0]                   in_key,
  input  logic [15:0]                   in_max_age,
  input  logic [31:0]                   in_now,
  output logic                          o_hit,
  output logic                          o_stale,
  output logic [ltc_pkg::SLOT_W-1:0]    o_slot,
  output logic                          o_evicted,
  output logic                          o_ev_stale,
  output logic [31:0]                   o_ev_key
);
  import ltc_pkg::*;

  logic [KEY_BITS-1:0] ekey    [ENTRIES];
  logic [31:0]         eexp    [ENTRIES];
  logic [IDX_W-1:0]    erank   [ENTRIES];
  logic [ENTRIES-1:0]  evalid;
  logic [CNT_W-1:0]    fill_count;
  logic [CAP_W-1:0]    capacity;

  cmd_t                cmd;
  logic [KEY_BITS-1:0] key;
  logic [31:0]         now, expiry;
  logic [IDX_W-1:0]    idx;
  logic                hit, stale;
  logic [IDX_W-1:0]    hslot;
  logic                best_ok;
  logic [IDX_W-1:0]    best;
  logic [31:0]         best_exp;
  logic [IDX_W-1:0]    best_rank;
  logic                free_ok;
  logic [IDX_W-1:0]    free_slot;
  logic [IDX_W-1:0]    ref_rank;
  logic                evicted, ev_stale;
  logic [KEY_BITS-1:0] ev_key;
  logic [SLOT_W-1:0]   slot;
  logic [32:0]         sum;
  logic [CNT_W-1:0]    cap_eff;

  assign sum     = {1'b0, in_now} + {17'd0, in_max_age};
  assign cap_eff = (capacity == '0) ? CNT_W'(1) :
                   ({{(CNT_W > CAP_W ? CNT_W - CAP_W : 0){1'b0}}, capacity} > CNT_W'(ENTRIES)) ?
                   CNT_W'(ENTRIES) : CNT_W'(capacity);

  logic cur_v;
  logic cand_early;
  assign cur_v = evalid[idx];

  // current entry beats the earliest found so far
  assign cand_early = cur_v && (!best_ok || eexp[idx] < best_exp ||
                      (eexp[idx] == best_exp && erank[idx] > best_rank));

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_W'(16);
    else if (cfg_we) capacity <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd    <= cmd_t'(in_cmd);
      key    <= in_key[KEY_BITS-1:0];
      now    <= in_now;
      expiry <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (ctl.clear) idx <= '0;
    else if (ctl.step) idx <= idx + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evalid     <= '0;
      fill_count <= '0;
    end else begin
      if (ctl.remove) begin
        evalid[best] <= 1'b0;
        fill_count   <= fill_count - CNT_W'(1);
      end
      if (ctl.insert && free_ok) begin
        evalid[free_slot] <= 1'b1;
        fill_count        <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit <= 1'b0; stale <= 1'b0; hslot <= '0;
      best_ok <= 1'b0; free_ok <= 1'b0;
      evicted <= 1'b0; ev_stale <= 1'b0; ev_key <= '0;
      slot <= '0;
    end
    if (ctl.step) begin
      unique case (ctl.pass)
        PASS_FIND: begin
          if (cmd != CMD_NONE && cur_v && ekey[idx] == key && !hit) begin
            hit <= 1'b1; hslot <= idx; ref_rank <= erank[idx];
            stale <= now > eexp[idx];
            slot <= SLOT_W'(idx);
          end
          if (!cur_v && !free_ok) begin
            free_ok <= 1'b1; free_slot <= idx;
          end
        end
        PASS_EARLY, PASS_LRU: begin
          if (!ctl.pick_lru && cur_v && (!best_ok ||
              (ctl.pass == PASS_EARLY && (eexp[idx] < best_exp ||
                (eexp[idx] == best_exp && erank[idx] > best_rank))) ||
              (ctl.pass == PASS_LRU && erank[idx] > best_rank))) begin
            best_ok <= 1'b1; best <= idx; best_exp <= eexp[idx]; best_rank <= erank[idx];
          end
        end
        PASS_SHIFT: begin
          if (cur_v) begin
            if (hit) begin
              if (erank[idx] < ref_rank) erank[idx] <= erank[idx] + IDX_W'(1);
            end else begin
              erank[idx] <= erank[idx] + IDX_W'(1);
            end
          end
        end
        default: begin
          if (hit && idx == hslot) erank[idx] <= '0;
        end
      endcase
    end
    if (ctl.pick_lru) best_ok <= 1'b0;
    if (ctl.pass == PASS_EARLY && ctl.step && ctl.clear) ev_stale <= sts.early_stale;
    if (ctl.refresh) eexp[hslot] <= expiry;
    if (ctl.remove) begin
      evicted <= 1'b1;
      ev_key  <= ekey[best];
      free_ok <= 1'b1;
      if (!free_ok || best < free_slot) free_slot <= best;
      for (int i = 0; i < ENTRIES; i++)
        if (evalid[i] && erank[i] > best_rank) erank[i] <= erank[i] - IDX_W'(1);
    end
    if (ctl.insert && free_ok) begin
      ekey[free_slot]  <= key;
      eexp[free_slot]  <= expiry;
      erank[free_slot] <= '0;
      slot             <= SLOT_W'(free_slot);
    end
  end

  assign sts.last        = (idx == IDX_W'(ENTRIES - 1));
  assign sts.hit         = hit;
  assign sts.is_put      = (cmd == CMD_PUT);
  assign sts.is_get      = (cmd == CMD_GET);
  assign sts.is_none     = (cmd == CMD_NONE);
  assign sts.full        = (fill_count >= cap_eff) && (fill_count != '0);
  assign sts.early_stale = cand_early ? (now > eexp[idx]) : (best_ok && (now > best_exp));
  assign sts.have_free   = free_ok;

  assign o_hit      = hit;
  assign o_stale    = stale;
  assign o_slot     = slot;
  assign o_evicted  = evicted;
  assign o_ev_stale = ev_stale;
  assign o_ev_key   = 32'(ev_key);
endmodule

// ===== rtl/lru_ttl_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_ttl_cache_replacement
// fully associative tag table with lru replacement and expiry
// ----------------------------------------------------------------------------
// channel | dir | word
// in      | in  | cmd, key, max_age, now
// out     | out | hit, stale, slot, evicted, evict_was_stale, evicted_key
// cfg     | in  | capacity (cfg_we, cfg_data)
//
// each scan pass reads one entry per cycle
// get/query or refreshing put: find pass; hit get, new put: also shift, insert
// one word in flight at a time
// reset clears valid bits and fill count at once, no clearing pass
// a stalled result holds until taken
module lru_ttl_cache_replacement (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ltc_pkg::CAP_W-1:0]  cfg_data,
  ltc_in_if.sink                     in_ch,
  ltc_out_if.source                  out_ch
);
  import ltc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_fire, out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  ltc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .ctl(ctl), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
  );

  ltc_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_data(cfg_data), .cfg_we(cfg_we),
    .in_cmd(in_ch.cmd), .in_key(in_ch.key), .in_max_age(in_ch.max_age), .in_now(in_ch.now),
    .o_hit(out_ch.hit), .o_stale(out_ch.stale), .o_slot(out_ch.slot),
    .o_evicted(out_ch.evicted), .o_ev_stale(out_ch.evict_was_stale),
    .o_ev_key(out_ch.evicted_key)
  );
endmodule

// ===== rtl/ltc_checker.sv =====
// ----------------------------------------------------------------------------
// ltc_checker
// port-level checks of the cache tag table
// ----------------------------------------------------------------------------
`include "lru_ttl_cache_replacement_macros.svh"
module ltc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        evicted,
  input logic        evict_was_stale,
  input logic [31:0] evicted_key,
  input logic        hit,
  input logic        stale
);
  `LTC_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  `LTC_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `LTC_ASSERT_IMP(a_ev_stale, clk, rst, out_valid && evict_was_stale, evicted)
  `LTC_ASSERT_IMP(a_ev_key, clk, rst, out_valid && !evicted, evicted_key == 32'd0)
  `LTC_ASSERT_IMP(a_stale_hit, clk, rst, out_valid && stale, hit)
endmodule

bind lru_ttl_cache_replacement ltc_checker u_ltc_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .evicted(out_ch.evicted),
  .evict_was_stale(out_ch.evict_was_stale), .evicted_key(out_ch.evicted_key),
  .hit(out_ch.hit), .stale(out_ch.stale)
);
